[sv/ptca_pkg.sv]
// ============================================================================
// ptca_pkg
// Shared types, constants and wiring functions of the PWM timer channel
// allocator.
// ============================================================================
`default_nettype none

package ptca_pkg;

    localparam int CHANNELS        = 16;
    localparam int TIMERS          = 4;
    localparam int USERS_PER_TIMER = 4;
    localparam int FREQ_BITS       = 26;

    // Channel ch is wired to timer (ch / CHAN_GROUP) % TIMER_WRAP.
    localparam int CHAN_GROUP = 2;
    localparam int TIMER_WRAP = 4;

    // Fixed field widths of the request and the response.
    localparam int FREQ_FIELD_W  = 26;
    localparam int CHAN_FIELD_W  = 4;
    localparam int TIMER_FIELD_W = 2;

    localparam int TIMER_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CHAN_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int USERS_W = $clog2(USERS_PER_TIMER + 1);
    localparam int CIDX_W  = (USERS_PER_TIMER > 1) ? $clog2(USERS_PER_TIMER) : 1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NONE_FREE  = 2'd1,
        ST_ZERO_FREQ  = 2'd2,
        ST_NOT_IN_USE = 2'd3
    } status_t;

    typedef struct packed {
        logic                      opcode;
        logic [FREQ_FIELD_W-1:0]   frequency_hz;
        logic [CHAN_FIELD_W-1:0]   release_channel;
    } req_t;

    typedef struct packed {
        logic                      success;
        logic [CHAN_FIELD_W-1:0]   granted_channel;
        logic [TIMER_FIELD_W-1:0]  granted_timer;
        status_t                   status;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    timer_next;
        logic    claim;
        logic    chan_next;
        logic    grant;
        logic    undo;
        logic    release_ch;
        logic    fail;
        status_t fail_code;
        logic    push;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic freq_zero;
        logic release_ok;
        logic timer_hit;
        logic timer_last;
        logic chan_hit;
        logic chan_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] ch;
    } chan_pick_t;

    // The index-th channel wired to timer t, in ascending channel order.
    function automatic chan_pick_t nth_chan(input logic [TIMER_W-1:0] t,
                                            input logic [CIDX_W-1:0]  i);
        chan_pick_t pick;
        int         ch;
        ch = (int'(i) / CHAN_GROUP) * (CHAN_GROUP * TIMER_WRAP)
             + int'(t) * CHAN_GROUP + int'(i) % CHAN_GROUP;
        pick.valid = (int'(t) < TIMER_WRAP) && (ch < CHANNELS);
        pick.ch    = CHAN_W'(ch);
        return pick;
    endfunction

    // Timer number that a channel is wired to.
    function automatic logic [TIMER_FIELD_W-1:0] chan_timer(
        input logic [CHAN_FIELD_W-1:0] ch);
        return TIMER_FIELD_W'((int'(ch) / CHAN_GROUP) % TIMER_WRAP);
    endfunction

endpackage

`default_nettype wire

[sv/pwm_timer_channel_allocator_unit.sv]
// ============================================================================
// pwm_timer_channel_allocator_unit
// Allocates and releases PWM channels over a small set of shared timers.
// ============================================================================
// One request is handled at a time and gives exactly one response. A request
// is captured, then decoded, then the timers are examined in order (up to
// four, first match or free timer wins) and then the channels on the chosen
// timer (up to four), and last the result is loaded into the output register.
// Releases and zero-frequency requests skip both scans. The request side is
// ready again the cycle after the response is loaded, even while that
// response still waits for its transfer.
`default_nettype none

module pwm_timer_channel_allocator_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ptca_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ptca_pkg::rsp_t      rsp
);
    import ptca_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ptca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptca_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[sv/ptca_datapath.sv]
// ============================================================================
// ptca_datapath
// Timer and channel tables, request and scan registers, and the response
// output register of the allocator.
// ============================================================================
`default_nettype none

module ptca_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ptca_pkg::req_t req,
    input  wire ptca_pkg::cmd_t cmd,
    output ptca_pkg::stat_t     stat,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ptca_pkg::rsp_t      rsp
);
    import ptca_pkg::*;

    logic [FREQ_BITS-1:0] timer_freq_reg  [TIMERS];
    logic [USERS_W-1:0]   timer_users_reg [TIMERS];
    logic [CHANNELS-1:0]  chan_busy_reg;
    logic                 rsp_valid_reg;

    req_t                 req_reg;
    logic [TIMER_W-1:0]   tidx_reg;
    logic [TIMER_W-1:0]   sel_reg;
    logic [CIDX_W-1:0]    cidx_reg;
    rsp_t                 res_reg;
    rsp_t                 rsp_reg;

    logic [FREQ_BITS-1:0]     req_freq;
    logic [CHAN_W-1:0]        rel_ch;
    logic [TIMER_FIELD_W-1:0] rel_timer_num;
    logic [TIMER_W-1:0]       rel_timer;
    logic                     rel_timer_in;
    logic [USERS_W-1:0]       rel_users_next;
    logic                     cand;
    chan_pick_t               pick;

    always_comb
    begin
        req_freq      = req_reg.frequency_hz[FREQ_BITS-1:0];
        rel_ch        = CHAN_W'(req_reg.release_channel);
        rel_timer_num = chan_timer(req_reg.release_channel);
        rel_timer     = TIMER_W'(rel_timer_num);
        rel_timer_in  = int'(rel_timer_num) < TIMERS;
        rel_users_next = (timer_users_reg[rel_timer] == '0) ? '0
                         : timer_users_reg[rel_timer] - USERS_W'(1);
        cand = (timer_freq_reg[tidx_reg] == req_freq) || (timer_freq_reg[tidx_reg] == '0);
        pick = nth_chan(sel_reg, cidx_reg);

        stat.is_release = req_reg.opcode == OP_RELEASE;
        stat.freq_zero  = req_freq == '0;
        stat.release_ok = (int'(req_reg.release_channel) < CHANNELS) && chan_busy_reg[rel_ch];
        stat.timer_hit  = cand && (timer_users_reg[tidx_reg] < USERS_W'(USERS_PER_TIMER));
        stat.timer_last = int'(tidx_reg) == TIMERS - 1;
        stat.chan_hit   = pick.valid && !chan_busy_reg[pick.ch];
        stat.chan_last  = int'(cidx_reg) == USERS_PER_TIMER - 1;
        stat.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    // Allocation state and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TIMERS; t++)
            begin
                timer_freq_reg[t]  <= '0;
                timer_users_reg[t] <= '0;
            end
            chan_busy_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.claim)
            begin
                timer_freq_reg[tidx_reg]  <= req_freq;
                timer_users_reg[tidx_reg] <= timer_users_reg[tidx_reg] + USERS_W'(1);
            end
            if (cmd.undo)
            begin
                timer_users_reg[sel_reg] <= timer_users_reg[sel_reg] - USERS_W'(1);
                if (timer_users_reg[sel_reg] == USERS_W'(1))
                begin
                    timer_freq_reg[sel_reg] <= '0;
                end
            end
            if (cmd.grant)
            begin
                chan_busy_reg[pick.ch] <= 1'b1;
            end
            if (cmd.release_ch)
            begin
                chan_busy_reg[rel_ch] <= 1'b0;
                if (rel_timer_in)
                begin
                    timer_users_reg[rel_timer] <= rel_users_next;
                    if (rel_users_next == '0)
                    begin
                        timer_freq_reg[rel_timer] <= '0;
                    end
                end
            end
            if (cmd.push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request, scan indexes and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req;
            tidx_reg <= '0;
        end
        if (cmd.timer_next)
        begin
            tidx_reg <= tidx_reg + TIMER_W'(1);
        end
        if (cmd.claim)
        begin
            sel_reg  <= tidx_reg;
            cidx_reg <= '0;
        end
        if (cmd.chan_next)
        begin
            cidx_reg <= cidx_reg + CIDX_W'(1);
        end
        if (cmd.grant)
        begin
            res_reg.success         <= 1'b1;
            res_reg.granted_channel <= CHAN_FIELD_W'(pick.ch);
            res_reg.granted_timer   <= TIMER_FIELD_W'(sel_reg);
            res_reg.status          <= ST_OK;
        end
        if (cmd.release_ch)
        begin
            res_reg.success         <= 1'b1;
            res_reg.granted_channel <= req_reg.release_channel;
            res_reg.granted_timer   <= rel_timer_num;
            res_reg.status          <= ST_OK;
        end
        if (cmd.undo || cmd.fail)
        begin
            res_reg.success         <= 1'b0;
            res_reg.granted_channel <= '0;
            res_reg.granted_timer   <= '0;
            res_reg.status          <= cmd.undo ? ST_NONE_FREE : cmd.fail_code;
        end
        if (cmd.push)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar g = 0; g < TIMERS; g++)
    begin : g_timer_chk
        a_users_bound: assert property (@(posedge clk) disable iff (!rst_n)
            timer_users_reg[g] <= USERS_W'(USERS_PER_TIMER))
            else $error("timer user count exceeds its limit");

        a_idle_timer_free: assert property (@(posedge clk) disable iff (!rst_n)
            timer_users_reg[g] == '0 |-> timer_freq_reg[g] == '0)
            else $error("timer without users keeps a frequency");
    end

    a_grant_free_chan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> pick.valid && !chan_busy_reg[pick.ch])
        else $error("granted channel is already busy");

endmodule

`default_nettype wire

[sv/ptca_ctrl.sv]
// ============================================================================
// ptca_ctrl
// Sequencer of the allocator: decodes a request, for an allocation scans timers and then
// the channels of the chosen timer, and hands the result to the output register.
// ============================================================================
`default_nettype none

module ptca_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire ptca_pkg::stat_t stat,
    output ptca_pkg::cmd_t       cmd
);
    import ptca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TSCAN,
        S_CSCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.fail_code = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_release)
                begin
                    if (stat.release_ok)
                    begin
                        cmd.release_ch = 1'b1;
                    end
                    else
                    begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = ST_NOT_IN_USE;
                    end
                    state_next = S_FINISH;
                end
                else if (stat.freq_zero)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_ZERO_FREQ;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_TSCAN;
                end
            end
            S_TSCAN:
            begin
                if (stat.timer_hit)
                begin
                    cmd.claim  = 1'b1;
                    state_next = S_CSCAN;
                end
                else if (stat.timer_last)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_NONE_FREE;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.timer_next = 1'b1;
                end
            end
            S_CSCAN:
            begin
                if (stat.chan_hit)
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.chan_last)
                begin
                    // No free channel on the timer: give the user slot back.
                    cmd.undo   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.chan_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;

    a_claim_to_cscan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |=> state_reg == S_CSCAN)
        else $error("timer claim not followed by channel scan");

    a_push_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free && state_reg == S_FINISH)
        else $error("result pushed into an occupied output register");

endmodule

`default_nettype wire
